/* design/ps2mc_pkg.sv */
// Shared types and constants for the PS/2 mouse packet cursor block.
// No dependencies; imported by every module of the block.
package ps2mc_pkg;

  // Position within the three-byte packet
  localparam logic [1:0] PHASE_STATUS = 2'd0;
  localparam logic [1:0] PHASE_DX     = 2'd1;
  localparam logic [1:0] PHASE_DY     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [1:0] REG_LIMIT_X     = 2'd1;
  localparam logic [1:0] REG_LIMIT_Y     = 2'd2;

  localparam logic [7:0] SENSITIVITY_RST = 8'd16;
  localparam logic [7:0] LIMIT_X_RST     = 8'd79;
  localparam logic [7:0] LIMIT_Y_RST     = 8'd24;

  // Button bits in the status byte and in the masks
  localparam logic [2:0] BTN_LEFT   = 3'h1;
  localparam logic [2:0] BTN_RIGHT  = 3'h2;
  localparam logic [2:0] BTN_MIDDLE = 3'h4;
  localparam logic [2:0] BTN_ALL    = BTN_LEFT | BTN_RIGHT | BTN_MIDDLE;

  // Packet queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] delta_x;
    logic [7:0] delta_y;
  } packet_t;

  typedef struct packed {
    logic [7:0] sensitivity;
    logic [7:0] limit_x;
    logic [7:0] limit_y;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* design/ps2mc_front.sv */
// Byte front end: tracks the packet phase, latches status and X delta,
// and pushes a complete packet into the queue. Depends on ps2mc_pkg.
module ps2mc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ps2mc_pkg::packet_t push_pkt_o
);
  import ps2mc_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [7:0] dx_q, dx_d;
  logic       accept;

  // Only the last byte of a packet needs room in the queue
  assign in_ready_o = !((phase_q == PHASE_DY) && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (phase_q == PHASE_DY);

  assign push_pkt_o.buttons = status_q[2:0] & BTN_ALL;
  assign push_pkt_o.delta_x = dx_q;
  assign push_pkt_o.delta_y = data_byte_i;

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    dx_d     = dx_q;
    if (accept) begin
      case (phase_q)
        PHASE_DX: begin
          dx_d    = data_byte_i;
          phase_d = PHASE_DY;
        end
        PHASE_DY: begin
          phase_d = PHASE_STATUS;
        end
        default: begin
          status_d = data_byte_i;
          phase_d  = PHASE_DX;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_STATUS;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dx_q     <= dx_d;
  end

endmodule

/* design/ps2mc_queue.sv */
// Two-entry packet queue between the byte front end and the cursor back end.
// Depends on ps2mc_pkg.
module ps2mc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ps2mc_pkg::packet_t     push_pkt_i,
  input  logic                   pop_i,
  output ps2mc_pkg::packet_t     pop_pkt_o,
  output ps2mc_pkg::queue_stat_t stat_o
);
  import ps2mc_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  packet_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_pkt_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

endmodule

/* design/ps2mc_back.sv */
// Cursor back end: scales the deltas (stage 1), then updates the clamped
// position and button edges into the output register (stage 2).
// Depends on ps2mc_pkg.
module ps2mc_back #(
  parameter int FRACTION_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ps2mc_pkg::cfg_t    cfg_i,
  input  logic               q_empty_i,
  input  ps2mc_pkg::packet_t pkt_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         cursor_col_o,
  output logic [7:0]         cursor_row_o,
  output logic [2:0]         pressed_mask_o,
  output logic [2:0]         released_mask_o,
  output logic               moved_o
);
  import ps2mc_pkg::*;

  localparam int PROD_W = 17;
  localparam int POS_W  = 8 + FRACTION_BITS;
  localparam int SHL    = (FRACTION_BITS >= 4) ? FRACTION_BITS - 4 : 0;
  localparam int SHR    = (FRACTION_BITS < 4) ? 4 - FRACTION_BITS : 0;
  localparam int STEP_W = PROD_W + SHL;
  localparam int SUM_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 2;

  // Stage 1: products
  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [2:0]               s1_btn_q;
  logic                     s1_moved_q;

  // Stage 2: position and output register
  logic [POS_W-1:0] pos_x_q, pos_x_d;
  logic [POS_W-1:0] pos_y_q, pos_y_d;
  logic [2:0]       held_q;
  logic             out_valid_q;
  logic [2:0]       pressed_q, released_q;
  logic             moved_q;

  logic s2_adv, s1_ready;

  logic signed [8:0]        sens_s;
  logic signed [7:0]        dx_s, dy_s;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [STEP_W-1:0] step_x, step_y;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic [POS_W-1:0]         hi_x, hi_y;

  function automatic logic [POS_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                             input logic [POS_W-1:0] hi);
    if (v[SUM_W-1]) begin
      clamp = '0;
    end else if (v > $signed(SUM_W'(hi))) begin
      clamp = hi;
    end else begin
      clamp = v[POS_W-1:0];
    end
  endfunction

  assign s2_adv   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_ready = !s1_valid_q || s2_adv;
  assign pop_o    = s1_ready && !q_empty_i;

  assign sens_s = $signed({1'b0, cfg_i.sensitivity});
  assign dx_s   = $signed(pkt_i.delta_x);
  assign dy_s   = $signed(pkt_i.delta_y);
  assign prod_x = PROD_W'(dx_s) * PROD_W'(sens_s);
  assign prod_y = PROD_W'(dy_s) * PROD_W'(sens_s);

  // Rescale step (Q4.4 gain, 4 frac bits) to position; the shift floors
  assign step_x = (STEP_W'(prod_x_q) <<< SHL) >>> SHR;
  assign step_y = (STEP_W'(prod_y_q) <<< SHL) >>> SHR;
  assign sum_x  = $signed(SUM_W'(pos_x_q)) + SUM_W'(step_x);
  assign sum_y  = $signed(SUM_W'(pos_y_q)) - SUM_W'(step_y);
  assign hi_x   = POS_W'(cfg_i.limit_x) << FRACTION_BITS;
  assign hi_y   = POS_W'(cfg_i.limit_y) << FRACTION_BITS;

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (s2_adv && s1_moved_q) begin
      pos_x_d = clamp(sum_x, hi_x);
      pos_y_d = clamp(sum_y, hi_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      held_q      <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= !q_empty_i;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
        held_q      <= s1_btn_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_x_q   <= prod_x;
      prod_y_q   <= prod_y;
      s1_btn_q   <= pkt_i.buttons;
      s1_moved_q <= (pkt_i.delta_x != '0) || (pkt_i.delta_y != '0);
    end
    if (s2_adv) begin
      pressed_q  <= s1_btn_q & ~held_q;
      released_q <= held_q & ~s1_btn_q;
      moved_q    <= s1_moved_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = pos_x_q[POS_W-1:FRACTION_BITS];
  assign cursor_row_o    = pos_y_q[POS_W-1:FRACTION_BITS];
  assign pressed_mask_o  = pressed_q;
  assign released_mask_o = released_q;
  assign moved_o         = moved_q;

endmodule

/* design/ps2_mouse_packet_cursor_top.sv */
// PS/2 mouse packet decoder with cursor tracking: one result per 3 bytes.
// Throughput: one byte per cycle unless a third byte meets a full queue;
// the position loop is a combinational add/clamp. A packet's third byte goes
// via the queue write, multiply stage and position/output register to a result.
// Reset (async, active low): phase, buttons and position cleared; registers
// return to sensitivity 16, limit_x 79, limit_y 24. Depends on ps2mc_pkg.
module ps2_mouse_packet_cursor_top #(
  parameter int FRACTION_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cursor_col_o,
  output logic [7:0] cursor_row_o,
  output logic [2:0] pressed_mask_o,
  output logic [2:0] released_mask_o,
  output logic       moved_o
);
  import ps2mc_pkg::*;

  cfg_t        cfg_q;
  packet_t     push_pkt, pop_pkt;
  logic        push, pop;
  queue_stat_t q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensitivity <= SENSITIVITY_RST;
      cfg_q.limit_x     <= LIMIT_X_RST;
      cfg_q.limit_y     <= LIMIT_Y_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SENSITIVITY: cfg_q.sensitivity <= cfg_data_i;
        REG_LIMIT_X:     cfg_q.limit_x     <= cfg_data_i;
        REG_LIMIT_Y:     cfg_q.limit_y     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ps2mc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .push_pkt_o (push_pkt)
  );

  ps2mc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_pkt_i(push_pkt),
    .pop_i     (pop),
    .pop_pkt_o (pop_pkt),
    .stat_o    (q_stat)
  );

  ps2mc_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_stat.empty),
    .pkt_i          (pop_pkt),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .pressed_mask_o (pressed_mask_o),
    .released_mask_o(released_mask_o),
    .moved_o        (moved_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("packet pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("packet popped from empty queue");

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pressed_mask_o & released_mask_o) == 3'b000))
    else $error("button both pressed and released");
`endif

endmodule

/* sim/tb_ps2_mouse_packet_cursor_top.sv */
// Self-checking testbench for ps2_mouse_packet_cursor_top: byte stream in, cursor reports out.
// Depends on ps2mc_pkg and the block's RTL; a scoreboard class tracks packets and position.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_cursor_top;
  import ps2mc_pkg::*;

  localparam int         FRAC         = 4;
  localparam logic [1:0] REG_NONE     = 2'd3;  // no register behind this index
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         NUM_PHASES   = 6;
  localparam int         PHASE_BYTES  = 141;
  localparam int         PRINT_CAP    = 40;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [2:0] pressed;
    logic [2:0] released;
    logic       moved;
  } cursor_report_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] cursor_col_o;
  logic [7:0] cursor_row_o;
  logic [2:0] pressed_mask_o;
  logic [2:0] released_mask_o;
  logic       moved_o;

  ps2_mouse_packet_cursor_top #(
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .pressed_mask_o (pressed_mask_o),
    .released_mask_o(released_mask_o),
    .moved_o        (moved_o)
  );

  class CursorTracker;
    logic [7:0]     gain;
    logic [7:0]     lim_x;
    logic [7:0]     lim_y;
    logic [1:0]     phase;
    logic [7:0]     status;
    logic [7:0]     dx;
    logic [2:0]     held;
    int             pos_x;
    int             pos_y;
    cursor_report_t expected_reports[$];
    int             mismatches;
    int             printed;

    function new();
      gain       = SENSITIVITY_RST;
      lim_x      = LIMIT_X_RST;
      lim_y      = LIMIT_Y_RST;
      phase      = PHASE_STATUS;
      status     = '0;
      dx         = '0;
      held       = '0;
      pos_x      = 0;
      pos_y      = 0;
      mismatches = 0;
      printed    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_SENSITIVITY: gain = val;
        REG_LIMIT_X:     lim_x = val;
        REG_LIMIT_Y:     lim_y = val;
        default: ;
      endcase
    endfunction

    // delta times Q4.4 gain at FRAC fraction bits, floored
    function longint scaled(logic [7:0] d);
      longint p;
      p = longint'($signed(d)) * longint'(gain) * (longint'(1) << FRAC);
      if (p >= 0) return p / 16;
      return -((-p + 15) / 16);
    endfunction

    function int clamp(longint v, logic [7:0] lim);
      longint hi;
      hi = longint'(lim) << FRAC;
      if (v < 0) return 0;
      if (v > hi) return int'(hi);
      return int'(v);
    endfunction

    function void note_byte(logic [7:0] b);
      cursor_report_t r;
      logic [2:0]     btn;
      case (phase)
        PHASE_DX: begin
          dx    = b;
          phase = PHASE_DY;
        end
        PHASE_DY: begin
          phase      = PHASE_STATUS;
          btn        = status[2:0] & BTN_ALL;
          r.pressed  = btn & ~held;
          r.released = held & ~btn;
          held       = btn;
          r.moved    = (dx != 8'd0) || (b != 8'd0);
          if (r.moved) begin
            pos_x = clamp(longint'(pos_x) + scaled(dx), lim_x);
            pos_y = clamp(longint'(pos_y) - scaled(b), lim_y);
          end
          r.col = 8'((pos_x >> FRAC) & 'hFF);
          r.row = 8'((pos_y >> FRAC) & 'hFF);
          expected_reports.push_back(r);
        end
        default: begin
          status = b;
          phase  = PHASE_DX;
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (printed < PRINT_CAP) begin
        printed++;
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    task check_report(cursor_report_t got);
      cursor_report_t want;
      if (expected_reports.size() == 0) begin
        report($sformatf("report with nothing pending (col %0d row %0d)", got.col, got.row));
        return;
      end
      want = expected_reports.pop_front();
      if (got.col != want.col)
        report($sformatf("cursor_col got %0d want %0d", got.col, want.col));
      if (got.row != want.row)
        report($sformatf("cursor_row got %0d want %0d", got.row, want.row));
      if (got.pressed != want.pressed)
        report($sformatf("pressed_mask got %b want %b", got.pressed, want.pressed));
      if (got.released != want.released)
        report($sformatf("released_mask got %b want %b", got.released, want.released));
      if (got.moved != want.moved)
        report($sformatf("moved got %b want %b", got.moved, want.moved));
    endtask
  endclass

  CursorTracker tracker;
  bit           calm;
  bit           hold_req;
  int           stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        stall_left  = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left  = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_report({cursor_col_o, cursor_row_o, pressed_mask_o,
                            released_mask_o, moved_o});
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_byte(b);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_packet(input logic [7:0] st, input logic [7:0] x, input logic [7:0] y);
    send_byte(st);
    send_byte(x);
    send_byte(y);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering bytes and let every pending report come out
  task automatic drain();
    sender_gap(1);
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] lx, input logic [7:0] ly);
    drain();
    cfg_write(REG_SENSITIVITY, s);
    cfg_write(REG_LIMIT_X, lx);
    cfg_write(REG_LIMIT_Y, ly);
  endtask

  function automatic logic [7:0] rand_delta();
    logic [7:0] d;
    case ($urandom_range(0, 5))
      0:       d = 8'h00;
      1: begin
        case ($urandom_range(0, 3))
          0:       d = 8'h7F;
          1:       d = 8'h80;
          2:       d = 8'hFF;
          default: d = 8'h01;
        endcase
      end
      2, 3:    d = 8'($signed($urandom_range(0, 16)) - 8);
      default: d = 8'($urandom_range(0, 255));
    endcase
    return d;
  endfunction

  initial begin
    int       sent;
    bit       no_gaps;
    tracker     = new();
    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, button edges, delta extremes, clamping
    send_packet({5'b0, BTN_LEFT}, 8'h01, 8'h00);
    send_packet({5'b0, BTN_ALL}, 8'h7F, 8'h80);
    send_packet(8'h00, 8'h80, 8'h7F);
    send_packet({5'b0, BTN_RIGHT}, 8'h00, 8'h00);
    // sign/overflow bits set in the status byte are ignored
    send_packet({5'b11111, BTN_MIDDLE}, 8'hFF, 8'hFF);
    // zero gain: moved but position only re-clamped
    set_config(8'd0, LIMIT_X_RST, LIMIT_Y_RST);
    send_packet(8'h00, 8'h05, 8'hFB);
    set_config(8'd255, 8'd255, 8'd255);
    send_packet(8'h00, 8'h7F, 8'h80);
    // limits lowered below the position: only re-clamped on movement
    set_config(8'd255, 8'd10, 8'd10);
    cfg_write(REG_NONE, 8'hA5);
    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'h00, 8'h01, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(SENSITIVITY_RST, LIMIT_X_RST, LIMIT_Y_RST);
        1: set_config(8'd0, 8'd0, 8'd0);
        2: set_config(8'd255, 8'd255, 8'd255);
        3: set_config(8'd1, 8'd200, 8'd3);
        4: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        default: set_config(8'd37, LIMIT_X_RST, LIMIT_Y_RST);
      endcase
      if (p == 3) cfg_write(REG_NONE, 8'h00);
      calm    = (p == NUM_PHASES - 1);
      no_gaps = (p == 2);
      // results stall for a long stretch while bytes keep coming
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES || tracker.phase != PHASE_STATUS) begin
        if (!calm && !no_gaps && $urandom_range(0, 11) == 0)
          sender_gap($urandom_range(1, 17));
        if (tracker.phase == PHASE_STATUS && $urandom_range(0, 19) == 0) begin
          // random byte: taken as the status byte of the next packet
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end else if (tracker.phase == PHASE_STATUS) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end else begin
          send_byte(rand_delta());
          sent++;
        end
      end
    end

    drain();
    if (tracker.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
